@@ rtl/dcq_pkg.sv @@
// Package for the delayed command queue: transaction layouts, action codes
// and stream widths. No dependencies.
package dcq_pkg;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  localparam int CMD_W      = 8;
  localparam int DELAY_W    = 32;
  localparam int PEND_W     = 3;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_ms;
    logic [CMD_W-1:0]   command;
    action_t            action;
  } in_item_t;

  typedef struct packed {
    logic [PEND_W-1:0] pending_count;
    logic              dropped;
    logic [CMD_W-1:0]  command_out;
    logic              send_valid;
  } out_item_t;

endpackage

@@ rtl/delayed_command_queue_unit.sv @@
// Delayed command queue, top level.
// Depends on dcq_pkg, dcq_pipe_reg and dcq_engine.
//
// Usage:
//   Slave stream carries one transaction per request. tuser[0] selects the
//   action: add a command (0) or one millisecond tick (1). On add, tdata
//   holds the command byte and its delay in milliseconds, counted from the
//   send of the previous command (or from the add, for an empty queue).
//   Master stream returns exactly one transaction per request: send flag and
//   command byte sent by a tick, drop flag for an add into a full queue, and
//   the number of entries still waiting.
// Throughput: one transaction per cycle while the master side keeps tready
//   high; the head compare and the pointer and timer updates are
//   combinational between the input register and the result register.
// Path: an accepted request is held in the input register, and its result
//   is then registered in the result register, from which it is taken.
// Reset: rst clears the slots, the entry count, the timer and both register
//   valids; the command store is not cleared and is read only once written.
// Stall: when the master side holds tready low, the result register holds,
//   the input register fills, and then s_axis_tready drops.
module delayed_command_queue_unit import dcq_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] command, [39:8] delay_ms
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] command_out, [10:8] pending_count, [15:11] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] send_valid, [1] dropped
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  in_item_t                  in_item;
  in_item_t                  held_item;
  logic [$bits(in_item_t)-1:0]  held_raw;
  logic                      held_valid;
  logic                      res_ready;
  logic                      fire;
  out_item_t                 result;
  logic [$bits(out_item_t)-1:0] out_raw;
  out_item_t                 out_item;

  always_comb begin
    in_item.action   = action_t'(s_axis_tuser[0]);
    in_item.command  = s_axis_tdata[CMD_W-1:0];
    in_item.delay_ms = s_axis_tdata[CMD_W +: DELAY_W];
  end

  dcq_pipe_reg #(
    .WIDTH($bits(in_item_t))
  ) u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (in_item),
    .out_valid(held_valid),
    .out_ready(res_ready),
    .out_data (held_raw)
  );

  assign held_item = in_item_t'(held_raw);
  assign fire      = held_valid && res_ready;

  dcq_engine #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (held_item),
    .result(result)
  );

  dcq_pipe_reg #(
    .WIDTH($bits(out_item_t))
  ) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (held_valid),
    .in_ready (res_ready),
    .in_data  (result),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_raw)
  );

  assign out_item     = out_item_t'(out_raw);
  assign m_axis_tdata = {(OUT_DATA_W - CMD_W - PEND_W)'(0),
                         out_item.pending_count, out_item.command_out};
  assign m_axis_tuser = {out_item.dropped, out_item.send_valid};

endmodule

@@ rtl/dcq_pipe_reg.sv @@
// One-entry register slice with valid/ready handshake.
// Used for the input register and the result register. No package use.
module dcq_pipe_reg #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid;
  logic [WIDTH-1:0] data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // payload needs no reset; load on every transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_data;
    end
  end

endmodule

@@ rtl/dcq_engine.sv @@
// Queue state, command/delay store and elapsed-time logic.
// Depends on dcq_pkg for the transaction layouts and action codes.
module dcq_engine import dcq_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  logic [CMD_W-1:0]   entry_command [QUEUE_DEPTH];
  logic [DELAY_W-1:0] entry_delay   [QUEUE_DEPTH];

  logic [PTR_W-1:0]   write_slot, write_slot_next;
  logic [PTR_W-1:0]   read_slot, read_slot_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [DELAY_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [CMD_W-1:0]   head_command;
  logic [DELAY_W-1:0] head_delay;

  logic               is_add;
  logic               full;
  logic               empty;
  logic               add_ok;
  logic               pop_ok;
  logic               do_write;
  logic               do_pop;
  logic [DELAY_W-1:0] elapsed_inc;
  logic [CNT_W-1:0]   count_after;
  logic [31:0]        count_wide;

  always_comb begin
    is_add      = (item.action == ACT_ADD);
    full        = (entry_count == FULL_COUNT);
    empty       = (entry_count == '0);
    elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + DELAY_W'(1);
    add_ok      = is_add && !full;
    pop_ok      = !is_add && !empty && (elapsed_inc >= head_delay);
    do_write    = fire && add_ok;
    do_pop      = fire && pop_ok;

    count_after = entry_count;
    if (add_ok) begin
      count_after = entry_count + CNT_W'(1);
    end else if (pop_ok) begin
      count_after = entry_count - CNT_W'(1);
    end
    entry_count_next = fire ? count_after : entry_count;

    write_slot_next = write_slot;
    if (do_write) begin
      write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + PTR_W'(1);
    end
    read_slot_next = read_slot;
    if (do_pop) begin
      read_slot_next = (read_slot == LAST_SLOT) ? '0 : read_slot + PTR_W'(1);
    end

    elapsed_ms_next = elapsed_ms;
    if (fire && !is_add) begin
      elapsed_ms_next = pop_ok ? '0 : elapsed_inc;
    end else if (do_write && empty) begin
      elapsed_ms_next = '0;
    end

    count_wide           = 32'(count_after);
    result.send_valid    = pop_ok;
    result.command_out   = pop_ok ? head_command : '0;
    result.dropped       = is_add && full;
    result.pending_count = count_wide[PEND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      read_slot   <= '0;
      entry_count <= '0;
      elapsed_ms  <= '0;
    end else begin
      write_slot  <= write_slot_next;
      read_slot   <= read_slot_next;
      entry_count <= entry_count_next;
      elapsed_ms  <= elapsed_ms_next;
    end
  end

  // Store with a registered head read; a write into an empty queue lands on
  // the head slot, so forward it.
  always_ff @(posedge clk) begin
    if (do_write) begin
      entry_command[write_slot] <= item.command;
      entry_delay[write_slot]   <= item.delay_ms;
    end
    if (do_write && (write_slot == read_slot_next)) begin
      head_command <= item.command;
      head_delay   <= item.delay_ms;
    end else begin
      head_command <= entry_command[read_slot_next];
      head_delay   <= entry_delay[read_slot_next];
    end
  end

endmodule

@@ rtl/dcq_checker.sv @@
// Port-level checks for the delayed command queue, bound to the top level.
// Depends on dcq_pkg for stream widths.
module dcq_checker import dcq_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // a send comes only from a tick, a drop only from an add
  a_send_not_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("send and drop flagged in one transaction");

  // a drop means the queue was full and stays full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[10:8] == 3'(QUEUE_DEPTH)))
    else $error("drop reported with queue not full");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((QUEUE_DEPTH > 7) || (m_axis_tdata[10:8] <= 3'(QUEUE_DEPTH))))
    else $error("pending count above queue depth");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // hold an offered request until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser)))
    else $error("request changed while stalled");

endmodule

bind delayed_command_queue_unit dcq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_dcq_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
